// ===== design/fpfa_pkg.sv =====
// Shared types and constants for the fixed partition fit allocator.
package fpfa_pkg;

	localparam int DEF_MAX_PARTITIONS = 16;
	localparam int DEF_SIZE_BITS = 16;

	localparam int AMOUNT_W = 16;
	localparam int INDEX_W = 4;
	localparam int WASTE_W = 16;

	typedef enum logic [0:0] {
		OP_ADD   = 1'b0,
		OP_ALLOC = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_ALLOCATED = 2'd0,
		ST_NO_FIT    = 2'd1,
		ST_ADDED     = 2'd2,
		ST_FULL      = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		FIT_FIRST = 2'd0,
		FIT_BEST  = 2'd1,
		FIT_WORST = 2'd2,
		FIT_NEXT  = 2'd3
	} policy_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_COMMIT,
		S_RESULT
	} state_t;

	typedef struct packed {
		op_t                 operation;
		logic [AMOUNT_W-1:0] size_amount;
	} item_t;

	typedef struct packed {
		status_t            status;
		logic [INDEX_W-1:0] block_index;
		logic [WASTE_W-1:0] waste;
	} result_t;

endpackage

// ===== design/fpfa_ctrl.sv =====
// Partition table memory with the sequencer that adds entries and scans for a fit.
module fpfa_ctrl import fpfa_pkg::*; #(
	parameter int MAX_PARTITIONS = DEF_MAX_PARTITIONS,
	parameter int SIZE_BITS = DEF_SIZE_BITS
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    req_valid,
	output logic    req_ready,
	input  item_t   req_data,
	input  policy_t policy,
	output logic    res_valid,
	input  logic    res_ready,
	output result_t res_data
);

	localparam int IW = (MAX_PARTITIONS > 1) ? $clog2(MAX_PARTITIONS) : 1;
	localparam int CW = $clog2(MAX_PARTITIONS + 1);
	localparam logic [CW-1:0] FULL_COUNT = CW'(MAX_PARTITIONS);

	// Each entry holds the taken flag above the partition size.
	logic [SIZE_BITS:0] table_mem [MAX_PARTITIONS];
	logic [SIZE_BITS:0] rd_data_s1;

	state_t state_q, state_d;
	logic [CW-1:0] count_q;
	logic [IW-1:0] last_idx_q;
	logic          last_valid_q;

	logic [SIZE_BITS-1:0] amount_q;
	logic [IW-1:0]        scan_idx_q;
	logic [CW-1:0]        issued_q;
	logic [IW-1:0]        idx_s1;
	logic                 last_s1;
	logic                 found_q;
	logic [IW-1:0]        pick_q;
	logic [SIZE_BITS-1:0] pick_size_q;
	result_t              res_q;

	logic                 accept;
	logic                 is_add;
	logic                 is_full;
	logic                 is_empty;
	logic [SIZE_BITS-1:0] req_amount;
	logic [IW-1:0]        start_idx;
	logic                 cur_taken;
	logic [SIZE_BITS-1:0] cur_size;
	logic                 fits;
	logic                 better;
	logic                 stop_early;
	logic                 scan_done;
	logic                 issue;
	logic                 mem_we;
	logic [IW-1:0]        mem_waddr;
	logic [SIZE_BITS:0]   mem_wdata;
	logic                 mem_re;
	logic [IW-1:0]        mem_raddr;

	function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] idx,
		input logic [CW-1:0] n);
		logic [CW-1:0] nxt;
		nxt = CW'(idx) + CW'(1);
		return (nxt == n) ? '0 : IW'(nxt);
	endfunction

	assign accept     = req_valid && req_ready;
	assign is_add     = (req_data.operation == OP_ADD);
	assign is_full    = (count_q == FULL_COUNT);
	assign is_empty   = (count_q == '0);
	assign req_amount = SIZE_BITS'(req_data.size_amount);

	// Next fit resumes at the last allocated partition when that one is still in range.
	assign start_idx = (policy == FIT_NEXT && last_valid_q && CW'(last_idx_q) < count_q) ?
		last_idx_q : '0;

	assign cur_taken  = rd_data_s1[SIZE_BITS];
	assign cur_size   = rd_data_s1[SIZE_BITS-1:0];
	assign fits       = !cur_taken && (cur_size >= amount_q);
	assign better     = fits && (!found_q ||
		(policy == FIT_BEST && cur_size < pick_size_q) ||
		(policy == FIT_WORST && cur_size > pick_size_q));
	assign stop_early = fits && (policy == FIT_FIRST || policy == FIT_NEXT);
	assign scan_done  = last_s1 || stop_early;
	assign issue      = (state_q == S_SCAN) && (issued_q != count_q) && !stop_early;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (!is_add && !is_empty) begin
						state_d = S_SCAN;
					end else begin
						state_d = S_RESULT;
					end
				end
			end
			S_SCAN: begin
				if (scan_done) begin
					state_d = S_COMMIT;
				end
			end
			S_COMMIT: state_d = S_RESULT;
			S_RESULT: begin
				if (res_ready) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		req_ready = (state_q == S_IDLE);
		res_valid = (state_q == S_RESULT);
		res_data  = res_q;
		mem_we    = (accept && is_add && !is_full) || (state_q == S_COMMIT && found_q);
		mem_waddr = (state_q == S_COMMIT) ? pick_q : IW'(count_q);
		mem_wdata = (state_q == S_COMMIT) ? {1'b1, pick_size_q} : {1'b0, req_amount};
		mem_re    = (accept && !is_add && !is_empty) || issue;
		mem_raddr = (state_q == S_SCAN) ? scan_idx_q : start_idx;
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			table_mem[mem_waddr] <= mem_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_re) begin
			rd_data_s1 <= table_mem[mem_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			last_idx_q   <= '0;
			last_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept && is_add && !is_full) begin
				count_q <= count_q + CW'(1);
			end
			if (state_q == S_COMMIT && found_q) begin
				last_idx_q   <= pick_q;
				last_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			amount_q <= req_amount;
			found_q  <= 1'b0;
			if (is_add) begin
				res_q.status      <= is_full ? ST_FULL : ST_ADDED;
				res_q.block_index <= is_full ? '0 : INDEX_W'(count_q);
				res_q.waste       <= '0;
			end else if (is_empty) begin
				res_q.status      <= ST_NO_FIT;
				res_q.block_index <= '0;
				res_q.waste       <= '0;
			end else begin
				issued_q   <= CW'(1);
				idx_s1     <= start_idx;
				last_s1    <= (count_q == CW'(1));
				scan_idx_q <= wrap_inc(start_idx, count_q);
			end
		end
		if (state_q == S_SCAN) begin
			if (issue) begin
				issued_q   <= issued_q + CW'(1);
				idx_s1     <= scan_idx_q;
				last_s1    <= ((issued_q + CW'(1)) == count_q);
				scan_idx_q <= wrap_inc(scan_idx_q, count_q);
			end
			if (better) begin
				found_q     <= 1'b1;
				pick_q      <= idx_s1;
				pick_size_q <= cur_size;
			end
		end
		if (state_q == S_COMMIT) begin
			if (found_q) begin
				res_q.status      <= ST_ALLOCATED;
				res_q.block_index <= INDEX_W'(pick_q);
				res_q.waste       <= WASTE_W'(pick_size_q - amount_q);
			end else begin
				res_q.status      <= ST_NO_FIT;
				res_q.block_index <= '0;
				res_q.waste       <= '0;
			end
		end
	end

	// The table is never written and read in the same cycle, so no forwarding is needed.
	assert property (@(posedge clk) disable iff (!arst_n) !(mem_we && mem_re))
		else $error("partition table written and read in one cycle");

	assert property (@(posedge clk) disable iff (!arst_n) count_q <= FULL_COUNT)
		else $error("partition count beyond table depth");

	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SCAN |-> (issued_q != '0 && issued_q <= count_q))
		else $error("scan issued more reads than partitions");

	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_COMMIT && found_q |-> pick_size_q >= amount_q)
		else $error("picked partition smaller than request");

	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_RESULT && !res_ready |=> state_q == S_RESULT && $stable(res_q))
		else $error("pending result dropped or changed");

endmodule

// ===== design/fixed_partition_fit_allocator.sv =====
// Top level of the fixed partition fit allocator: policy register, sequencer and output register.
//
// Takes one item at a time. An add's result is registered in the sequencer and passes to the
// output register when that register can take it; the sequencer then goes idle and can accept
// the next item. An allocate reads the filled entries of the partition table one entry per cycle
// through its single read port, then commits the pick and registers its result the same way;
// first fit and next fit end the scan at the first hit. The output register lets the next item
// be accepted while a finished result still waits to be taken. The fit policy may be written
// only while no item is in flight.
module fixed_partition_fit_allocator import fpfa_pkg::*; #(
	parameter int MAX_PARTITIONS = DEF_MAX_PARTITIONS,
	parameter int SIZE_BITS = DEF_SIZE_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_ready,
	input  item_t       req_data,
	output logic        rsp_valid,
	input  logic        rsp_ready,
	output result_t     rsp_data,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_wdata
);

	policy_t policy_q;
	logic    rsp_valid_q;
	result_t rsp_q;
	logic    res_valid;
	logic    res_ready;
	result_t res_data;

	fpfa_ctrl #(
		.MAX_PARTITIONS(MAX_PARTITIONS),
		.SIZE_BITS(SIZE_BITS)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req_data(req_data),
		.policy(policy_q),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res_data(res_data)
	);

	assign res_ready = !rsp_valid_q || rsp_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			policy_q    <= FIT_FIRST;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				policy_q <= policy_t'(cfg_wdata);
			end
			if (res_valid && res_ready) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			rsp_q <= res_data;
		end
	end

endmodule

// ===== sim/tb_top.sv =====
// Self-checking testbench for the fixed partition fit allocator.
module tb_top;
	import fpfa_pkg::*;

	localparam int TABLE_DEPTH = DEF_MAX_PARTITIONS;
	localparam int N_ROWS = 30;
	localparam int BEATS_PER_POLICY = 80;
	localparam int HOLD_CYCLES = 400;

	typedef enum logic {
		ROW_BEAT,
		ROW_POLICY
	} row_kind_t;

	typedef struct packed {
		row_kind_t kind;
		policy_t   policy;
		item_t     beat;
		logic      typed;
		result_t   want;
	} stim_row_t;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    req_valid = 1'b0;
	logic    req_ready;
	item_t   req_data = '0;
	logic    rsp_valid;
	logic    rsp_ready = 1'b0;
	result_t rsp_data;
	logic    cfg_we = 1'b0;
	logic    [1:0] cfg_wdata = '0;

	// Mirror of the partition table, updated in the order beats are accepted.
	logic    [AMOUNT_W-1:0] tbl_size [TABLE_DEPTH];
	logic    tbl_taken [TABLE_DEPTH];
	int      tbl_count = 0;
	int      last_pick = 0;
	logic    last_pick_valid = 1'b0;
	policy_t tbl_policy = FIT_FIRST;

	result_t results_due [$];
	result_t oldest;
	int      fail_count = 0;

	int      tx_idle_pct = 0;
	int      rx_idle_pct = 0;
	logic    hold_phase = 1'b0;
	logic    hold_spent = 1'b0;
	int      hold_left = 0;

	stim_row_t directed_rows [N_ROWS] = '{
		'{ROW_BEAT, FIT_FIRST, '{OP_ALLOC, 16'd0}, 1'b1, '{ST_NO_FIT, 4'd0, 16'd0}},
		'{ROW_BEAT, FIT_FIRST, '{OP_ADD, 16'd100}, 1'b1, '{ST_ADDED, 4'd0, 16'd0}},
		'{ROW_BEAT, FIT_FIRST, '{OP_ADD, 16'd0}, 1'b1, '{ST_ADDED, 4'd1, 16'd0}},
		'{ROW_BEAT, FIT_FIRST, '{OP_ADD, 16'hFFFF}, 1'b1, '{ST_ADDED, 4'd2, 16'd0}},
		'{ROW_BEAT, FIT_FIRST, '{OP_ADD, 16'd300}, 1'b1, '{ST_ADDED, 4'd3, 16'd0}},
		'{ROW_BEAT, FIT_FIRST, '{OP_ADD, 16'd200}, 1'b1, '{ST_ADDED, 4'd4, 16'd0}},
		'{ROW_BEAT, FIT_FIRST, '{OP_ADD, 16'd500}, 1'b1, '{ST_ADDED, 4'd5, 16'd0}},
		'{ROW_POLICY, FIT_NEXT, '{OP_ADD, 16'd0}, 1'b0, '0},
		'{ROW_BEAT, FIT_FIRST, '{OP_ALLOC, 16'd50}, 1'b0, '0},
		'{ROW_POLICY, FIT_FIRST, '{OP_ADD, 16'd0}, 1'b0, '0},
		'{ROW_BEAT, FIT_FIRST, '{OP_ALLOC, 16'd150}, 1'b0, '0},
		'{ROW_BEAT, FIT_FIRST, '{OP_ALLOC, 16'hFFFF}, 1'b1, '{ST_NO_FIT, 4'd0, 16'd0}},
		'{ROW_POLICY, FIT_BEST, '{OP_ADD, 16'd0}, 1'b0, '0},
		'{ROW_BEAT, FIT_FIRST, '{OP_ALLOC, 16'd150}, 1'b0, '0},
		'{ROW_BEAT, FIT_FIRST, '{OP_ALLOC, 16'd0}, 1'b0, '0},
		'{ROW_POLICY, FIT_WORST, '{OP_ADD, 16'd0}, 1'b0, '0},
		'{ROW_BEAT, FIT_FIRST, '{OP_ALLOC, 16'd50}, 1'b0, '0},
		'{ROW_POLICY, FIT_NEXT, '{OP_ADD, 16'd0}, 1'b0, '0},
		'{ROW_BEAT, FIT_FIRST, '{OP_ALLOC, 16'd10}, 1'b0, '0},
		'{ROW_BEAT, FIT_FIRST, '{OP_ADD, 16'd1}, 1'b1, '{ST_ADDED, 4'd6, 16'd0}},
		'{ROW_BEAT, FIT_FIRST, '{OP_ADD, 16'd65534}, 1'b1, '{ST_ADDED, 4'd7, 16'd0}},
		'{ROW_BEAT, FIT_FIRST, '{OP_ADD, 16'd1000}, 1'b1, '{ST_ADDED, 4'd8, 16'd0}},
		'{ROW_BEAT, FIT_FIRST, '{OP_ADD, 16'd1000}, 1'b1, '{ST_ADDED, 4'd9, 16'd0}},
		'{ROW_BEAT, FIT_FIRST, '{OP_ADD, 16'd40000}, 1'b1, '{ST_ADDED, 4'd10, 16'd0}},
		'{ROW_BEAT, FIT_FIRST, '{OP_ADD, 16'd7}, 1'b1, '{ST_ADDED, 4'd11, 16'd0}},
		'{ROW_BEAT, FIT_FIRST, '{OP_ADD, 16'd32768}, 1'b1, '{ST_ADDED, 4'd12, 16'd0}},
		'{ROW_BEAT, FIT_FIRST, '{OP_ADD, 16'd1000}, 1'b1, '{ST_ADDED, 4'd13, 16'd0}},
		'{ROW_BEAT, FIT_FIRST, '{OP_ADD, 16'd12345}, 1'b1, '{ST_ADDED, 4'd14, 16'd0}},
		'{ROW_BEAT, FIT_FIRST, '{OP_ADD, 16'd0}, 1'b1, '{ST_ADDED, 4'd15, 16'd0}},
		'{ROW_BEAT, FIT_FIRST, '{OP_ADD, 16'hFFFF}, 1'b1, '{ST_FULL, 4'd0, 16'd0}}
	};

	fixed_partition_fit_allocator uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req_data  (req_data),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp_data  (rsp_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #10 clk = ~clk;

	function automatic result_t place_or_fit(input item_t it);
		result_t r;
		int      start;
		int      k;
		int      i;
		int      pick;
		logic    found;
		r = '0;
		if (it.operation == OP_ADD) begin
			if (tbl_count >= TABLE_DEPTH) begin
				r.status = ST_FULL;
			end else begin
				tbl_size[tbl_count] = it.size_amount;
				tbl_taken[tbl_count] = 1'b0;
				r.status = ST_ADDED;
				r.block_index = tbl_count[INDEX_W-1:0];
				tbl_count++;
			end
			return r;
		end
		r.status = ST_NO_FIT;
		if (tbl_count == 0)
			return r;
		start = 0;
		if (tbl_policy == FIT_NEXT && last_pick_valid && last_pick < tbl_count)
			start = last_pick;
		found = 1'b0;
		pick = 0;
		for (k = 0; k < tbl_count; k++) begin
			i = start + k;
			if (i >= tbl_count)
				i -= tbl_count;
			// First and next fit stop at the first hit; best and worst look at every entry.
			if (!tbl_taken[i] && tbl_size[i] >= it.size_amount &&
					!(found && (tbl_policy == FIT_FIRST || tbl_policy == FIT_NEXT))) begin
				if (!found ||
						(tbl_policy == FIT_BEST && tbl_size[i] < tbl_size[pick]) ||
						(tbl_policy == FIT_WORST && tbl_size[i] > tbl_size[pick])) begin
					pick = i;
					found = 1'b1;
				end
			end
		end
		if (found) begin
			tbl_taken[pick] = 1'b1;
			last_pick = pick;
			last_pick_valid = 1'b1;
			r.status = ST_ALLOCATED;
			r.block_index = pick[INDEX_W-1:0];
			r.waste = tbl_size[pick] - it.size_amount;
		end
		return r;
	endfunction

	// Called at a falling edge; returns at the falling edge after the beat is taken.
	task automatic offer_beat(input item_t it, input logic typed, input result_t typed_want);
		result_t predicted;
		while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		req_data <= it;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		predicted = place_or_fit(it);
		results_due.push_back(typed ? typed_want : predicted);
		@(negedge clk);
	endtask

	task automatic write_policy(input policy_t p);
		req_valid <= 1'b0;
		while (results_due.size() != 0)
			@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= p;
		@(negedge clk);
		cfg_we <= 1'b0;
		tbl_policy = p;
	endtask

	always @(negedge clk) begin
		if (hold_phase && !hold_spent) begin
			hold_left = HOLD_CYCLES;
			hold_spent = 1'b1;
		end
		if (hold_left != 0) begin
			hold_left--;
			rsp_ready <= 1'b0;
		end else begin
			rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready) begin
			if (results_due.size() == 0) begin
				$display("%0t: result beat with nothing expected: status %0d index %0d waste %0d",
					$time, rsp_data.status, rsp_data.block_index, rsp_data.waste);
				fail_count++;
			end else begin
				oldest = results_due.pop_front();
				if (rsp_data.status !== oldest.status) begin
					$display("%0t: status expected %0d actual %0d",
						$time, oldest.status, rsp_data.status);
					fail_count++;
				end
				if (rsp_data.block_index !== oldest.block_index) begin
					$display("%0t: block_index expected %0d actual %0d",
						$time, oldest.block_index, rsp_data.block_index);
					fail_count++;
				end
				if (rsp_data.waste !== oldest.waste) begin
					$display("%0t: waste expected %0d actual %0d",
						$time, oldest.waste, rsp_data.waste);
					fail_count++;
				end
			end
		end
	end

	initial begin : stimulus
		int    row;
		int    phase;
		int    sub;
		int    n;
		item_t nxt;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (row = 0; row < N_ROWS; row++) begin
			if (directed_rows[row].kind == ROW_POLICY)
				write_policy(directed_rows[row].policy);
			else
				offer_beat(directed_rows[row].beat, directed_rows[row].typed,
					directed_rows[row].want);
		end

		for (phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					tx_idle_pct = 0;
					rx_idle_pct = 0;
				end
				1: begin
					tx_idle_pct = 86;
					rx_idle_pct = 0;
				end
				2: begin
					tx_idle_pct = 0;
					rx_idle_pct = 86;
				end
				default: begin
					tx_idle_pct = 12;
					rx_idle_pct = 12;
				end
			endcase
			for (sub = 0; sub < 4; sub++) begin
				write_policy(policy_t'($urandom_range(3)));
				for (n = 0; n < BEATS_PER_POLICY; n++) begin
					nxt.operation = op_t'($urandom_range(1));
					case ($urandom_range(3))
						0: nxt.size_amount = AMOUNT_W'($urandom_range(65535));
						1: nxt.size_amount = AMOUNT_W'($urandom_range(1100));
						2: nxt.size_amount = $urandom_range(1) ? 16'hFFFF : 16'd0;
						default: nxt.size_amount = AMOUNT_W'($urandom);
					endcase
					offer_beat(nxt, 1'b0, '0);
				end
			end
		end

		// Long receiver hold-off while the sender keeps pushing, so the input backs up.
		write_policy(policy_t'($urandom_range(3)));
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		hold_phase = 1'b1;
		for (n = 0; n < 40; n++) begin
			nxt.operation = op_t'($urandom_range(1));
			nxt.size_amount = AMOUNT_W'($urandom);
			offer_beat(nxt, 1'b0, '0);
		end

		req_valid <= 1'b0;
		while (results_due.size() != 0)
			@(negedge clk);
		repeat (40) @(negedge clk);
		if (fail_count == 0)
			$display("fixed_partition_fit_allocator verification clean");
		else
			$display("fixed_partition_fit_allocator verification failed");
		$finish;
	end

	initial begin
		#20000000;
		$display("fixed_partition_fit_allocator verification failed");
		$finish;
	end

endmodule
